// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define DTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DTS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dts_pkg.sv
`default_nettype none

package dts_pkg;

    // Drum geometry
    localparam int NUM_DRUMS      = 2;
    localparam int ZONES_PER_DRUM = 256;
    localparam int QUEUE_DEPTH    = 4;

    // Field widths
    localparam int BLK_W   = 11;
    localparam int WC_W    = 16;
    localparam int ADDR_W  = 20;
    localparam int TAG_W   = 8;
    localparam int ZONE_W  = 8;
    localparam int PAGE_W  = 10;
    localparam int SEC_W   = 13;
    localparam int TDATA_W = 56;

    // Transfer sizes in words
    localparam logic [WC_W-1:0] SECT_WORDS = WC_W'(256);
    localparam logic [WC_W-1:0] ZONE_WORDS = WC_W'(1024);

    // Sectors on one drum and on all drums
    localparam logic [SEC_W-1:0] PER_DRUM_SECT = SEC_W'(ZONES_PER_DRUM * 4);
    localparam logic [SEC_W-1:0] TOTAL_SECT    = SEC_W'(NUM_DRUMS * ZONES_PER_DRUM * 4);

    // Armed free bit codes
    localparam logic [1:0] ARMED_NONE = 2'd0;
    localparam logic [1:0] ARMED_ONE  = 2'd1;
    localparam logic [1:0] ARMED_TWO  = 2'd2;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_ACCEPT = 2'd1,
        MODE_REJECT = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_EXCHANGE = 3'd0,
        KIND_DONE     = 3'd1,
        KIND_FAILED   = 3'd2,
        KIND_REFUSED  = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_STRAY    = 3'd5
    } kind_t;

    // One request; block_number sits in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0]  request_tag;
        logic              is_read;
        logic [ADDR_W-1:0] memory_address;
        logic [WC_W-1:0]   word_count;
        logic [BLK_W-1:0]  block_number;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    // Result payload; tag sits in the lowest bits
    typedef struct packed {
        logic [4:0]        pad;
        logic [1:0]        armed;
        logic [WC_W-1:0]   residual;
        logic              read_dir;
        logic [1:0]        quarter;
        logic [PAGE_W-1:0] memory_page;
        logic              page_mode;
        logic [1:0]        sector;
        logic [ZONE_W-1:0] zone;
        logic              drum;
        logic [TAG_W-1:0]  tag;
    } out_data_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  enqueue;
        logic  pop;
        logic  advance;
        logic  arm;
        logic  disarm;
        logic  load;
        kind_t kind;
        logic  last;
    } dts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  refuse;
        logic  full;
        logic  empty;
        logic  one_left;
        logic  more;
        logic  out_free;
    } dts_status_t;

endpackage

`default_nettype wire

// File: rtl/core/drum_transfer_sequencer_core.sv
// A refused, full, failed, done or stray result is loaded into the output register from the
// DECIDE state; an exchange command first passes FETCH and ISSUE to read the queue head.
// A new input beat is taken only once the last one is done (s_tready only in IDLE); the
// registered read port of the request queue adds the FETCH state. Output stalls hold the
// next result. Reset clears queue pointers, count, words done, armed bit and output valid;
// queue contents stay undefined until written.
`default_nettype none

module drum_transfer_sequencer_core
    import dts_pkg::*;
#(
    parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // block_number, word_count, memory_address, is_read, request_tag
    input  wire logic [TDATA_W-1:0] s_tdata,
    // mode
    input  wire logic [1:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // tag, drum, zone, sector, page_mode, memory_page, quarter, read_dir, residual, armed
    output logic [TDATA_W-1:0]      m_tdata,
    // kind
    output logic [2:0]              m_tuser,
    output logic                    m_tlast
);

    dts_cmd_t    cmd;
    dts_status_t st;

    dts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    dts_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/dts_ram.sv
`default_nettype none

module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/dts_ctrl.sv
`default_nettype none

module dts_ctrl
    import dts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire dts_status_t st,
    output dts_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_ISSUE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Decode the captured beat into datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.kind   = KIND_EXCHANGE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                    unique case (st.mode)
                        MODE_SUBMIT:
                        begin
                            if (st.refuse)
                            begin
                                cmd.load = 1'b1;
                                cmd.kind = KIND_REFUSED;
                                cmd.last = 1'b1;
                            end
                            else if (st.full)
                            begin
                                cmd.load = 1'b1;
                                cmd.kind = KIND_FULL;
                                cmd.last = 1'b1;
                            end
                            else
                            begin
                                cmd.enqueue = 1'b1;
                                if (st.empty)
                                begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        MODE_ACCEPT:
                        begin
                            cmd.arm = !st.empty;
                        end
                        MODE_REJECT:
                        begin
                            if (!st.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.kind   = KIND_FAILED;
                                cmd.last   = st.one_left;
                                cmd.pop    = 1'b1;
                                cmd.disarm = st.one_left;
                                if (!st.one_left)
                                begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        MODE_FINISH:
                        begin
                            if (st.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.kind   = KIND_STRAY;
                                cmd.last   = 1'b1;
                                cmd.disarm = 1'b1;
                            end
                            else if (st.more)
                            begin
                                cmd.advance = 1'b1;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                cmd.load   = 1'b1;
                                cmd.kind   = KIND_DONE;
                                cmd.last   = st.one_left;
                                cmd.pop    = 1'b1;
                                cmd.disarm = st.one_left;
                                if (!st.one_left)
                                begin
                                    state_next = S_FETCH;
                                end
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // Let the queue head settle through the read register
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (st.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.kind   = KIND_EXCHANGE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/dts_datapath.sv
`default_nettype none

module dts_datapath
    import dts_pkg::*;
#(
    parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dts_cmd_t           cmd,
    output dts_status_t             st,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]         s_tuser,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [2:0]              m_tuser,
    output logic                    m_tlast
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    req_t              in_req_reg;
    mode_t             in_mode_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [WC_W-1:0]   words_done_reg;
    logic              page_reg;
    logic [1:0]        armed_reg;
    logic [1:0]        armed_next;
    logic              out_valid_reg;
    out_data_t         out_data_reg;
    out_data_t         out_data_next;
    kind_t             out_kind_reg;
    logic              out_last_reg;

    logic [REQ_W-1:0]  head_bits;
    req_t              head;

    logic [SEC_W-1:0]  reach;
    logic [SEC_W-1:0]  sec;
    logic [SEC_W-1:0]  zone_off;
    logic [ADDR_W-1:0] pa;
    logic              drum_hi;
    logic [WC_W-1:0]   remain;
    logic              page_ok;
    logic [WC_W-1:0]   wd_new;

    // Request queue
    dts_ram #(
        .WIDTH(REQ_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .we   (cmd.enqueue),
        .waddr(tail_reg),
        .wdata(in_req_reg),
        .raddr(head_reg),
        .rdata(head_bits)
    );

    assign head = req_t'(head_bits);

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_req_reg  <= req_t'(s_tdata);
            in_mode_reg <= mode_t'(s_tuser);
        end
    end

    // Refuse zero, unaligned or out-of-range requests
    assign reach = SEC_W'({in_req_reg.block_number, 1'b0}) + SEC_W'(in_req_reg.word_count[15:8]);

    // Locate the current exchange of the head request
    assign sec      = SEC_W'({head.block_number, 1'b0}) + SEC_W'(words_done_reg[15:8]);
    assign drum_hi  = (sec >= PER_DRUM_SECT);
    assign zone_off = drum_hi ? (sec - PER_DRUM_SECT) : sec;
    assign pa       = head.memory_address + ADDR_W'(words_done_reg);
    assign remain   = head.word_count - words_done_reg;
    assign page_ok  = (sec[1:0] == 2'd0) && (pa[9:0] == 10'd0) && (remain >= ZONE_WORDS);
    assign wd_new   = words_done_reg + (page_reg ? ZONE_WORDS : SECT_WORDS);

    // Report status to the controller
    always_comb
    begin
        st.mode     = in_mode_reg;
        st.refuse   = (in_req_reg.word_count == '0) || (in_req_reg.word_count[7:0] != 8'd0)
                      || (in_req_reg.memory_address[7:0] != 8'd0) || (reach > TOTAL_SECT);
        st.full     = (count_reg == CNT_FULL);
        st.empty    = (count_reg == '0);
        st.one_left = (count_reg == CNT_W'(1));
        st.more     = (wd_new < head.word_count);
        st.out_free = !out_valid_reg || m_tready;
    end

    // Update the armed free bit
    always_comb
    begin
        armed_next = armed_reg;
        if (cmd.disarm)
        begin
            armed_next = ARMED_NONE;
        end
        else if (cmd.arm)
        begin
            armed_next = drum_hi ? ARMED_TWO : ARMED_ONE;
        end
    end

    // Form the result beat
    always_comb
    begin
        out_data_next       = '0;
        out_data_next.armed = armed_next;
        case (cmd.kind) inside
            KIND_EXCHANGE:
            begin
                out_data_next.tag         = head.request_tag;
                out_data_next.drum        = drum_hi;
                out_data_next.zone        = zone_off[ZONE_W+1:2];
                out_data_next.page_mode   = page_ok;
                out_data_next.memory_page = pa[ADDR_W-1:10];
                out_data_next.sector      = page_ok ? 2'd0 : sec[1:0];
                out_data_next.quarter     = page_ok ? 2'd0 : pa[9:8];
                out_data_next.read_dir    = head.is_read;
            end
            KIND_DONE:
            begin
                out_data_next.tag = head.request_tag;
            end
            KIND_FAILED:
            begin
                out_data_next.tag      = head.request_tag;
                out_data_next.residual = remain;
            end
            KIND_REFUSED, KIND_FULL:
            begin
                out_data_next.tag      = in_req_reg.request_tag;
                out_data_next.residual = in_req_reg.word_count;
            end
            default:
            begin
                out_data_next.tag = '0;
            end
        endcase
    end

    // Advance queue pointers, progress and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            words_done_reg <= '0;
            page_reg       <= 1'b0;
            armed_reg      <= ARMED_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            if (cmd.enqueue)
            begin
                tail_reg  <= (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.pop)
            begin
                head_reg       <= (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                count_reg      <= count_reg - CNT_W'(1);
                words_done_reg <= '0;
            end
            else if (cmd.advance)
            begin
                words_done_reg <= wd_new;
            end
            if (cmd.load && (cmd.kind == KIND_EXCHANGE))
            begin
                page_reg <= page_ok;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/dts_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dts_checker
    import dts_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [2:0]         m_tuser,
    input wire logic               m_tlast
);

    logic               out_stall;
    logic               out_chain;
    logic               out_stray;
    logic [TDATA_W+3:0] out_beat;
    out_data_t          out_word;

    // Decode the result beat
    assign out_stall = m_tvalid && !m_tready;
    assign out_chain = (m_tuser == KIND_DONE) || (m_tuser == KIND_FAILED);
    assign out_stray = m_tvalid && (m_tuser == KIND_STRAY);
    assign out_beat  = {m_tdata, m_tuser, m_tlast};
    assign out_word  = m_tdata;

    // No result while in reset; the output register may still be unknown at the first edge
    `DTS_ASSERT_RST(a_reset_quiet, !rst_n |-> (m_tvalid !== 1'b1), "result valid in reset")

    // One input beat in work at a time
    `DTS_ASSERT(a_one_in_work, (s_tvalid && s_tready) |=> !s_tready, "second beat taken at once")

    // Stalled result beat holds
    `DTS_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable(out_beat)), "stalled beat changed")

    // Only done or failed results are followed by another
    `DTS_ASSERT(a_first_of_two, (m_tvalid && !m_tlast) |-> out_chain, "unexpected non-last beat")

    // Stray completion leaves nothing armed
    `DTS_ASSERT(a_stray_disarms, out_stray |-> (out_word.armed == ARMED_NONE), "stray beat armed")

endmodule

bind drum_transfer_sequencer_core dts_checker u_dts_checker (.*);

`default_nettype wire
